// ----- hdl/cbl_pkg.sv -----
// ----------------------------------------------------------------------------
// cbl_pkg
// Types and codes shared by the color keyed blitter files.
// ----------------------------------------------------------------------------
package cbl_pkg;

	localparam int unsigned PIXEL_BITS = 32;
	localparam int unsigned COUNT_BITS = 13;
	localparam int unsigned SIZE_BITS  = 7;
	localparam int unsigned CFG_IDX_BITS = 3;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_FILL  = 2'd2,
		REQ_COPY  = 2'd3
	} req_kind_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_S0_WIDTH  = 3'd0,
		CFG_S0_HEIGHT = 3'd1,
		CFG_S1_WIDTH  = 3'd2,
		CFG_S1_HEIGHT = 3'd3,
		CFG_KEY       = 3'd4
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_READ_WAIT,
		ST_FILL,
		ST_COPY,
		ST_DRAIN,
		ST_RESULT
	} cbl_state_t;

endpackage

// ----- hdl/cbl_if.sv -----
// ----------------------------------------------------------------------------
// cbl channel interfaces
// Request, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbl_req_if import cbl_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [1:0]            req_type;
	logic                  surface;
	logic signed [7:0]     x_pos;
	logic signed [7:0]     y_pos;
	logic [SIZE_BITS-1:0]  rect_width;
	logic [SIZE_BITS-1:0]  rect_height;
	logic [PIXEL_BITS-1:0] pixel_color;

	modport source (output valid, req_type, surface, x_pos, y_pos, rect_width,
		rect_height, pixel_color, input ready);
	modport sink (input valid, req_type, surface, x_pos, y_pos, rect_width,
		rect_height, pixel_color, output ready);
endinterface

interface cbl_res_if import cbl_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] read_pixel;
	logic [COUNT_BITS-1:0] pixels_written;
	logic                  out_of_bounds;

	modport source (output valid, read_pixel, pixels_written, out_of_bounds,
		input ready);
	modport sink (input valid, read_pixel, pixels_written, out_of_bounds,
		output ready);
endinterface

interface cbl_cfg_if import cbl_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [PIXEL_BITS-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/color_keyed_blitter.sv -----
// Each item runs ST_START, then ST_READ_WAIT for an in-bounds read, the ST_FILL walk for a
// nonempty fill, or the ST_COPY walk and ST_DRAIN for a nonempty copy, then ST_RESULT.
// Throughput: one item at a time, one pixel per cycle, set by the single
// surface memory write port (copy overlaps source read with destination write).
// Reset clears control state, sets the surface sizes to 64 and clears the key; surface
// memory is not cleared and holds no meaning until written.
// ----------------------------------------------------------------------------
// color_keyed_blitter
// Pixel read/write, rectangle fill and color keyed copy over two surfaces.
// ----------------------------------------------------------------------------
module color_keyed_blitter import cbl_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = 64,
	parameter int unsigned MAX_HEIGHT = 64
) (
	input  logic  clk,
	input  logic  arst_n,
	cbl_req_if.sink   req,
	cbl_res_if.source res,
	cbl_cfg_if.sink   cfg
);

	localparam int unsigned SURF_WORDS = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned MEM_WORDS  = 2 * SURF_WORDS;
	localparam int unsigned AW         = $clog2(MEM_WORDS);

	cbl_state_t state_q, state_d;

	// config registers
	logic [SIZE_BITS-1:0]  s0_w_q, s0_h_q, s1_w_q, s1_h_q;
	logic [PIXEL_BITS-1:0] key_q;

	// latched request
	req_kind_t             op_q;
	logic                  sel_q;
	logic [7:0]            x_q, y_q;
	logic [SIZE_BITS-1:0]  rw_q, rh_q;
	logic [PIXEL_BITS-1:0] color_q;

	// walk and result state
	logic [SIZE_BITS-1:0]  col_q, row_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [PIXEL_BITS-1:0] rd_q;
	logic                  oob_q;

	// copy write stage
	logic                  cp_v_s1;
	logic [AW-1:0]         cp_addr_s1;

	// output register
	logic                  out_v_q;
	logic [PIXEL_BITS-1:0] out_pix_q;
	logic [COUNT_BITS-1:0] out_cnt_q;
	logic                  out_oob_q;

	// memory ports
	logic                  mem_we, mem_re;
	logic [AW-1:0]         mem_waddr, mem_raddr;
	logic [PIXEL_BITS-1:0] mem_wdata, mem_rdata;

	logic                  in_acc;
	logic                  tgt_sel;
	logic [SIZE_BITS-1:0]  w_eff [2];
	logic [SIZE_BITS-1:0]  h_eff [2];
	logic [SIZE_BITS-1:0]  lim_w, lim_h;
	logic [9:0]            px, py;
	logic                  tgt_in, walk_last, walk_empty;
	logic [AW-1:0]         tgt_addr, src_addr;

	function automatic logic [SIZE_BITS-1:0] sat_w(input logic [SIZE_BITS-1:0] v);
		return (32'(v) > MAX_WIDTH) ? SIZE_BITS'(MAX_WIDTH) : v;
	endfunction

	function automatic logic [SIZE_BITS-1:0] sat_h(input logic [SIZE_BITS-1:0] v);
		return (32'(v) > MAX_HEIGHT) ? SIZE_BITS'(MAX_HEIGHT) : v;
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic sel, input logic [8:0] cx,
			input logic [8:0] cy);
		return (sel ? AW'(SURF_WORDS) : '0) + AW'(cy) * AW'(MAX_WIDTH) + AW'(cx);
	endfunction

	assign in_acc    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	assign res.valid          = out_v_q;
	assign res.read_pixel     = out_pix_q;
	assign res.pixels_written = out_cnt_q;
	assign res.out_of_bounds  = out_oob_q;

	always_comb begin
		w_eff[0] = sat_w(s0_w_q);
		w_eff[1] = sat_w(s1_w_q);
		h_eff[0] = sat_h(s0_h_q);
		h_eff[1] = sat_h(s1_h_q);
	end

	// a copy writes the other surface
	assign tgt_sel = (op_q == REQ_COPY) ? ~sel_q : sel_q;

	assign px = {{2{x_q[7]}}, x_q} + {3'b000, col_q};
	assign py = {{2{y_q[7]}}, y_q} + {3'b000, row_q};

	assign tgt_in = !px[9] && !py[9]
		&& (px[8:0] < {2'b00, w_eff[tgt_sel]})
		&& (py[8:0] < {2'b00, h_eff[tgt_sel]});

	assign tgt_addr = addr_of(tgt_sel, px[8:0], py[8:0]);
	assign src_addr = addr_of(sel_q, {2'b00, col_q}, {2'b00, row_q});

	assign lim_w = (op_q == REQ_FILL) ? rw_q : w_eff[sel_q];
	assign lim_h = (op_q == REQ_FILL) ? rh_q : h_eff[sel_q];
	assign walk_empty = (lim_w == '0) || (lim_h == '0);
	assign walk_last  = (col_q == lim_w - 1'b1) && (row_q == lim_h - 1'b1);

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = tgt_addr;
		mem_wdata = color_q;
		mem_re    = 1'b0;
		mem_raddr = (state_q == ST_COPY) ? src_addr : tgt_addr;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				case (op_q)
					REQ_WRITE: begin
						mem_we  = tgt_in;
						state_d = ST_RESULT;
					end
					REQ_READ: begin
						mem_re  = tgt_in;
						state_d = tgt_in ? ST_READ_WAIT : ST_RESULT;
					end
					REQ_FILL: state_d = walk_empty ? ST_RESULT : ST_FILL;
					REQ_COPY: state_d = walk_empty ? ST_RESULT : ST_COPY;
					default:  state_d = ST_RESULT;
				endcase
			end
			ST_READ_WAIT: state_d = ST_RESULT;
			ST_FILL: begin
				mem_we = tgt_in;
				if (walk_last) begin
					state_d = ST_RESULT;
				end
			end
			ST_COPY: begin
				mem_re = 1'b1;
				if (walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_RESULT;
			ST_RESULT: begin
				if (!out_v_q || res.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		// source pixel from the previous cycle lands on the destination unless it equals the key
		if (cp_v_s1 && (mem_rdata != key_q)) begin
			mem_we    = 1'b1;
			mem_waddr = cp_addr_s1;
			mem_wdata = mem_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_w_q <= SIZE_BITS'(64);
			s0_h_q <= SIZE_BITS'(64);
			s1_w_q <= SIZE_BITS'(64);
			s1_h_q <= SIZE_BITS'(64);
			key_q  <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_S0_WIDTH:  s0_w_q <= cfg.data[SIZE_BITS-1:0];
				CFG_S0_HEIGHT: s0_h_q <= cfg.data[SIZE_BITS-1:0];
				CFG_S1_WIDTH:  s1_w_q <= cfg.data[SIZE_BITS-1:0];
				CFG_S1_HEIGHT: s1_h_q <= cfg.data[SIZE_BITS-1:0];
				CFG_KEY:       key_q  <= cfg.data;
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			cnt_q   <= '0;
			cp_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (in_acc) begin
				col_q <= '0;
				row_q <= '0;
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + COUNT_BITS'(mem_we);
				if ((state_q == ST_FILL || state_q == ST_COPY) && !walk_last) begin
					if (col_q == lim_w - 1'b1) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
			end
			cp_v_s1 <= (state_q == ST_COPY) && tgt_in;
			if (state_q == ST_RESULT && (!out_v_q || res.ready)) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q    <= req_kind_t'(req.req_type);
			sel_q   <= req.surface;
			x_q     <= req.x_pos;
			y_q     <= req.y_pos;
			rw_q    <= req.rect_width;
			rh_q    <= req.rect_height;
			color_q <= req.pixel_color;
			rd_q    <= '0;
			oob_q   <= 1'b0;
		end else begin
			if (state_q == ST_START && (op_q == REQ_WRITE || op_q == REQ_READ) && !tgt_in) begin
				oob_q <= 1'b1;
			end
			if (state_q == ST_READ_WAIT) begin
				rd_q <= mem_rdata;
			end
		end
		cp_addr_s1 <= tgt_addr;
		if (state_q == ST_RESULT && (!out_v_q || res.ready)) begin
			out_pix_q <= rd_q;
			out_cnt_q <= cnt_q;
			out_oob_q <= oob_q;
		end
	end

	cbl_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MEM_WORDS)
	) u_surface_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

`ifndef NO_ASSERTIONS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_START) && (cnt_q == '0))
		else $error("accepted item did not start with a cleared count");

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ_WAIT) |-> !mem_we)
		else $error("memory written while a pixel read is pending");

	a_copy_stage_origin: assert property (@(posedge clk) disable iff (!arst_n)
		cp_v_s1 |-> $past(state_q == ST_COPY))
		else $error("copy write stage loaded outside a copy walk");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q == ST_RESULT))
		else $error("result raised without a finished item");
`endif

endmodule

// ----- hdl/cbl_ram.sv -----
// ----------------------------------------------------------------------------
// cbl_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cbl_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
